>>> hdl/dll_pkg.sv
// ----------------------------------------------------------------------------
// dll_pkg: shared types and codes of the doubly linked list manager
// Request and response words, operation codes, status codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dll_pkg;

  // Request word modes
  localparam logic [1:0] MODE_APPEND  = 2'd0;
  localparam logic [1:0] MODE_PREPEND = 2'd1;
  localparam logic [1:0] MODE_INSERT  = 2'd2;
  localparam logic [1:0] MODE_REMOVE  = 2'd3;

  // Response status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] item_value;
    logic [9:0]         anchor_handle;
    logic               place_left;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [9:0]         new_handle;
    logic signed [31:0] removed_value;
    logic [10:0]        element_count;
  } out_word_t;

  // Resolved operation, after end-of-list anchors and error checks
  typedef enum logic [2:0] {
    OP_APPEND,
    OP_PREPEND,
    OP_INS_LEFT,
    OP_INS_RIGHT,
    OP_REMOVE,
    OP_ERR_EMPTY,
    OP_ERR_FULL
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_SPLICE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request word and issue memory reads
    logic link;    // take handle, first link writes, update head/tail/size
    logic splice;  // second link writes of a mid-list insert
    logic finish;  // raise the result strobe next cycle
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic splice_needed;
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/doubly_linked_list_manager.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_manager: fixed-pool doubly linked list
// Append, prepend, insert beside an anchor, or remove the front node; each
// word returns one result word.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Append,
// prepend, remove and inserts at either end of the list take a load step
// reading the anchor links, the stack top and the head node, then a link
// step writing the links. A mid-list insert adds a splice step, since the
// previous and next link memories have one write port and each needs two
// writes. The result word is shown for exactly one cycle with done high,
// in the cycle busy falls, and must be captured then: it cannot be held
// off. Handles after reset are issued 0, 1, 2, ...; released handles are
// reused last-in first-out. No memory clearing pass is needed after reset.
`default_nettype none

module doubly_linked_list_manager #(
  parameter int NODES      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire dll_pkg::in_word_t request,
  output logic                   done,
  output dll_pkg::out_word_t     response
);

  dll_pkg::cmd_t  cmd;
  dll_pkg::stat_t stat;

  // Sequencer
  dll_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Memories and list registers
  dll_dpath #(.NODES(NODES), .VALUE_BITS(VALUE_BITS)) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .request  (request),
    .stat     (stat),
    .done     (done),
    .response (response)
  );

endmodule

`default_nettype wire

>>> hdl/dll_ram.sv
// ----------------------------------------------------------------------------
// dll_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/dll_ctrl.sv
// ----------------------------------------------------------------------------
// dll_ctrl: operation sequencer
// Steps each accepted word through the link phase and, for a mid-list
// insert, the splice phase, then raises the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module dll_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire dll_pkg::stat_t  stat,
  output dll_pkg::cmd_t        cmd,
  output logic                 busy
);

  dll_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dll_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      dll_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = dll_pkg::ST_LINK;
        end
      end
      dll_pkg::ST_LINK: begin
        cmd.link = 1'b1;
        if (stat.splice_needed) begin
          state_next = dll_pkg::ST_SPLICE;
        end else begin
          cmd.finish = 1'b1;
          state_next = dll_pkg::ST_IDLE;
        end
      end
      dll_pkg::ST_SPLICE: begin
        cmd.splice = 1'b1;
        cmd.finish = 1'b1;
        state_next = dll_pkg::ST_IDLE;
      end
      default: begin
        state_next = dll_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != dll_pkg::ST_IDLE);

endmodule

`default_nettype wire

>>> hdl/dll_dpath.sv
// ----------------------------------------------------------------------------
// dll_dpath: node memories, list registers and free-handle stack
// Holds value, previous-link and next-link memories, the head, tail and
// size registers, and the stack of released handles. Handles never used
// since reset are handed out in order from a high-water mark.
// ----------------------------------------------------------------------------
`default_nettype none

module dll_dpath #(
  parameter int NODES      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dll_pkg::cmd_t     cmd,
  input  wire dll_pkg::in_word_t request,
  output dll_pkg::stat_t         stat,
  output logic                   done,
  output dll_pkg::out_word_t     response
);

  localparam int HW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  // Word registers
  dll_pkg::op_t    op;
  logic [HW-1:0]   anchor_q;
  logic [31:0]     value_q;
  logic [HW-1:0]   hnew;

  // List registers
  logic [HW-1:0]   head;
  logic [HW-1:0]   tail;
  logic [CW-1:0]   size;
  logic [CW-1:0]   maxsize;
  logic [CW-1:0]   size_next;

  // Memory ports
  logic                  val_we,  prv_we,  nxt_we,  stk_we;
  logic [HW-1:0]         val_waddr, prv_waddr, nxt_waddr, stk_waddr;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [HW-1:0]         prv_wdata, nxt_wdata, stk_wdata;
  logic [HW-1:0]         nxt_raddr;
  logic [VALUE_BITS-1:0] val_rdata;
  logic [HW-1:0]         prv_rdata, nxt_rdata, stk_rdata;

  logic [9:0]      anchor_red;
  logic [HW+9:0]   anchor_wide;
  logic [HW-1:0]   anchor_idx;
  dll_pkg::op_t    op_dec;
  logic            fresh;
  logic [HW-1:0]   h;
  logic [HW+9:0]   h_wide;
  logic [CW+10:0]  cnt_wide;
  logic [31:0]     removed_ext;
  logic            adding;

  // Reduce anchor modulo the pool size by shifted compare-subtract
  always_comb begin
    anchor_red = request.anchor_handle;
    for (int k = 9; k >= 0; k--) begin
      if ((NODES << k) < 1024) begin
        if (anchor_red >= 10'(NODES << k)) begin
          anchor_red = anchor_red - 10'(NODES << k);
        end
      end
    end
  end

  assign anchor_wide = {{HW{1'b0}}, anchor_red};
  assign anchor_idx  = anchor_wide[HW-1:0];

  // Resolve the requested mode against the current list
  always_comb begin
    op_dec = dll_pkg::OP_ERR_FULL;
    priority if (request.mode == dll_pkg::MODE_REMOVE) begin
      op_dec = (size == '0) ? dll_pkg::OP_ERR_EMPTY : dll_pkg::OP_REMOVE;
    end else if (request.mode == dll_pkg::MODE_INSERT && size == '0) begin
      op_dec = dll_pkg::OP_ERR_EMPTY;
    end else if (size == CW'(NODES)) begin
      op_dec = dll_pkg::OP_ERR_FULL;
    end else if (request.mode == dll_pkg::MODE_APPEND) begin
      op_dec = dll_pkg::OP_APPEND;
    end else if (request.mode == dll_pkg::MODE_PREPEND) begin
      op_dec = dll_pkg::OP_PREPEND;
    end else if (request.place_left) begin
      op_dec = (anchor_idx == head) ? dll_pkg::OP_PREPEND : dll_pkg::OP_INS_LEFT;
    end else begin
      op_dec = (anchor_idx == tail) ? dll_pkg::OP_APPEND : dll_pkg::OP_INS_RIGHT;
    end
  end

  // Capture the word
  always_ff @(posedge clk) begin
    if (rst) begin
      op <= dll_pkg::OP_ERR_EMPTY;
    end else if (cmd.load) begin
      op <= op_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      anchor_q <= anchor_idx;
      value_q  <= request.item_value;
    end
    if (cmd.link) begin
      hnew <= h;
    end
  end

  assign stat.splice_needed = (op == dll_pkg::OP_INS_LEFT) ||
                              (op == dll_pkg::OP_INS_RIGHT);

  assign adding = (op == dll_pkg::OP_APPEND) || (op == dll_pkg::OP_PREPEND) ||
                  (op == dll_pkg::OP_INS_LEFT) || (op == dll_pkg::OP_INS_RIGHT);

  // Take a never-used handle at the high-water mark, else pop the stack
  assign fresh = (size == maxsize);
  assign h     = fresh ? size[HW-1:0] : stk_rdata;

  always_comb begin
    size_next = size;
    if (cmd.link) begin
      if (adding) begin
        size_next = size + CW'(1);
      end else if (op == dll_pkg::OP_REMOVE) begin
        size_next = size - CW'(1);
      end
    end
  end

  // Value width adaptation
  generate
    if (VALUE_BITS <= 32) begin : g_wr_narrow
      assign val_wdata = value_q[VALUE_BITS-1:0];
    end else begin : g_wr_wide
      assign val_wdata = {{(VALUE_BITS-32){1'b0}}, value_q};
    end
    if (VALUE_BITS >= 32) begin : g_rd_wide
      assign removed_ext = val_rdata[31:0];
    end else begin : g_rd_narrow
      assign removed_ext = {{(32-VALUE_BITS){val_rdata[VALUE_BITS-1]}}, val_rdata};
    end
  endgenerate

  // Memory write selection
  always_comb begin
    val_we    = 1'b0;
    val_waddr = h;
    prv_we    = 1'b0;
    prv_waddr = h;
    prv_wdata = h;
    nxt_we    = 1'b0;
    nxt_waddr = h;
    nxt_wdata = h;
    stk_we    = 1'b0;
    stk_waddr = size_next[HW-1:0];
    stk_wdata = head;
    if (cmd.link) begin
      unique case (op)
        dll_pkg::OP_APPEND: begin
          val_we = 1'b1;
          if (size != '0) begin
            nxt_we    = 1'b1;
            nxt_waddr = tail;
            nxt_wdata = h;
            prv_we    = 1'b1;
            prv_waddr = h;
            prv_wdata = tail;
          end
        end
        dll_pkg::OP_PREPEND: begin
          val_we = 1'b1;
          if (size != '0) begin
            prv_we    = 1'b1;
            prv_waddr = head;
            prv_wdata = h;
            nxt_we    = 1'b1;
            nxt_waddr = h;
            nxt_wdata = head;
          end
        end
        dll_pkg::OP_INS_LEFT: begin
          val_we    = 1'b1;
          nxt_we    = 1'b1;
          nxt_waddr = prv_rdata;
          nxt_wdata = h;
          prv_we    = 1'b1;
          prv_waddr = h;
          prv_wdata = prv_rdata;
        end
        dll_pkg::OP_INS_RIGHT: begin
          val_we    = 1'b1;
          prv_we    = 1'b1;
          prv_waddr = nxt_rdata;
          prv_wdata = h;
          nxt_we    = 1'b1;
          nxt_waddr = h;
          nxt_wdata = nxt_rdata;
        end
        dll_pkg::OP_REMOVE: begin
          stk_we = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (cmd.splice) begin
      prv_we = 1'b1;
      nxt_we = 1'b1;
      if (op == dll_pkg::OP_INS_LEFT) begin
        prv_waddr = anchor_q;
        prv_wdata = hnew;
        nxt_waddr = hnew;
        nxt_wdata = anchor_q;
      end else begin
        prv_waddr = hnew;
        prv_wdata = anchor_q;
        nxt_waddr = anchor_q;
        nxt_wdata = hnew;
      end
    end
  end

  // Advance head, tail, size and high-water mark
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      size    <= '0;
      maxsize <= '0;
    end else if (cmd.link) begin
      size <= size_next;
      if (adding && fresh) begin
        maxsize <= maxsize + CW'(1);
      end
      unique case (op)
        dll_pkg::OP_APPEND: begin
          tail <= h;
          if (size == '0) begin
            head <= h;
          end
        end
        dll_pkg::OP_PREPEND: begin
          head <= h;
          if (size == '0) begin
            tail <= h;
          end
        end
        dll_pkg::OP_REMOVE: begin
          if (size > CW'(1)) begin
            head <= nxt_rdata;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result word, loaded in the link phase and strobed on finish
  assign h_wide   = {{10{1'b0}}, h};
  assign cnt_wide = {{11{1'b0}}, size_next};

  always_ff @(posedge clk) begin
    if (cmd.link) begin
      response.status        <= (op == dll_pkg::OP_ERR_EMPTY) ? dll_pkg::STATUS_EMPTY :
                                (op == dll_pkg::OP_ERR_FULL)  ? dll_pkg::STATUS_FULL  :
                                                                dll_pkg::STATUS_OK;
      response.new_handle    <= adding ? h_wide[9:0] : 10'd0;
      response.removed_value <= (op == dll_pkg::OP_REMOVE) ? removed_ext : 32'd0;
      response.element_count <= cnt_wide[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  assign nxt_raddr = (request.mode == dll_pkg::MODE_REMOVE) ? head : anchor_idx;

  // Node memories and free-handle stack
  dll_ram #(.WIDTH(VALUE_BITS), .DEPTH(NODES)) u_val (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (head),
    .rdata (val_rdata)
  );

  dll_ram #(.WIDTH(HW), .DEPTH(NODES)) u_prv (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (anchor_idx),
    .rdata (prv_rdata)
  );

  dll_ram #(.WIDTH(HW), .DEPTH(NODES)) u_nxt (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  dll_ram #(.WIDTH(HW), .DEPTH(NODES)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (size[HW-1:0]),
    .rdata (stk_rdata)
  );

endmodule

`default_nettype wire

>>> hdl/dll_checker.sv
// ----------------------------------------------------------------------------
// dll_checker: port-level checks for the list manager
// Watches the start/busy handshake and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module dll_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire dll_pkg::out_word_t response
);

  // Reset leaves the block idle with no strobe
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("busy or done after reset");

  // An accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // A result only follows a busy cycle, and busy drops with it
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe without preceding work");

  // One strobe per word: never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

  // Status code is one of the defined values
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (response.status == dll_pkg::STATUS_OK ||
              response.status == dll_pkg::STATUS_EMPTY ||
              response.status == dll_pkg::STATUS_FULL))
    else $error("undefined status code");

endmodule

bind doubly_linked_list_manager dll_checker u_chk (.*);

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for doubly_linked_list_manager
// Issues list operations through the start/busy handshake, predicts each
// result word from a local copy of the list (node tables, head, tail, size and
// the free-handle stack) and compares every strobed word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int NODES = 1024;

  typedef enum {AT_HEAD, AT_TAIL, AT_INNER, AT_ANY} anchor_pick_t;

  typedef struct {
    dll_pkg::in_word_t word;
    int                gap;
  } pending_op_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  dll_pkg::in_word_t  request = '0;
  logic               done;
  dll_pkg::out_word_t response;

  // Local copy of the list state
  logic signed [31:0] node_val  [NODES];
  logic [9:0]         node_prev [NODES];
  logic [9:0]         node_next [NODES];
  logic [9:0]         free_stk  [NODES];
  logic [10:0]        free_top;
  logic [9:0]         lst_head;
  logic [9:0]         lst_tail;
  logic [10:0]        lst_size;

  pending_op_t        op_q[$];
  dll_pkg::out_word_t due_results[$];

  bit took = 1'b0;
  bit loaded = 1'b0;
  int idle_left = 0;
  int burst_left = 0;
  int sent_cnt = 0;
  int err_count = 0;

  doubly_linked_list_manager #(
    .NODES      (NODES),
    .VALUE_BITS (32)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic log_mismatch(input string field, input logic [31:0] got,
                              input logic [31:0] want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch in %0s at %0t: got %0h, want %0h", field, $time, got, want);
  endtask

  // Apply one operation to the local list and queue the word it must return
  task automatic apply_list_op(input dll_pkg::in_word_t w);
    dll_pkg::out_word_t r;
    logic [9:0] h;
    logic [9:0] n;
    logic [9:0] a;
    r = '0;
    a = w.anchor_handle;
    if (w.mode == dll_pkg::MODE_REMOVE) begin
      if (lst_size == 0) begin
        r.status = dll_pkg::STATUS_EMPTY;
      end else begin
        h = lst_head;
        r.removed_value = node_val[h];
        if (lst_size > 1) lst_head = node_next[h];
        lst_size--;
        if (free_top < NODES) begin
          free_stk[free_top] = h;
          free_top++;
        end
      end
    end else if (w.mode == dll_pkg::MODE_INSERT && lst_size == 0) begin
      r.status = dll_pkg::STATUS_EMPTY;
    end else if (lst_size >= NODES || free_top == 0) begin
      r.status = dll_pkg::STATUS_FULL;
    end else begin
      // take the handle on top of the free stack
      free_top--;
      h = free_stk[free_top];
      node_val[h] = w.item_value;
      lst_size++;
      r.new_handle = h;
      if (w.mode == dll_pkg::MODE_APPEND ||
          (w.mode == dll_pkg::MODE_INSERT && !w.place_left && a == lst_tail)) begin
        if (lst_size == 1) begin
          lst_head = h;
          lst_tail = h;
        end else begin
          node_next[lst_tail] = h;
          node_prev[h] = lst_tail;
          lst_tail = h;
        end
      end else if (w.mode == dll_pkg::MODE_PREPEND ||
                   (w.place_left && a == lst_head)) begin
        if (lst_size == 1) begin
          lst_head = h;
          lst_tail = h;
        end else begin
          node_prev[lst_head] = h;
          node_next[h] = lst_head;
          lst_head = h;
        end
      end else if (w.place_left) begin
        // splice between anchor and its predecessor
        n = node_prev[a];
        node_next[n] = h;
        node_prev[h] = n;
        node_prev[a] = h;
        node_next[h] = a;
      end else begin
        // splice between anchor and its successor
        n = node_next[a];
        node_prev[n] = h;
        node_next[h] = n;
        node_next[a] = h;
        node_prev[h] = a;
      end
    end
    r.element_count = lst_size;
    due_results.insert(due_results.size(), r);
  endtask

  // Queue one word once the previous one is taken; anchors come from the live list
  task automatic send(input logic [1:0] mode, input logic [31:0] value,
                      input anchor_pick_t pick, input logic left);
    pending_op_t op;
    logic [9:0] h;
    int k;
    do begin
      @(posedge clk);
      #1;
    end while (op_q.size() != 0);
    // occasionally hold off until every result word is back
    if (sent_cnt == 25 || $urandom_range(0, 49) == 0) begin
      while (due_results.size() != 0) begin
        @(posedge clk);
        #1;
      end
    end
    op.word.mode = mode;
    op.word.item_value = value;
    op.word.place_left = left;
    k = 0;
    h = lst_head;
    if (lst_size == 0) begin
      h = 10'($urandom_range(0, NODES - 1));
    end else begin
      case (pick)
        AT_HEAD: k = 0;
        AT_TAIL: k = int'(lst_size) - 1;
        AT_INNER: k = (lst_size > 2) ? $urandom_range(1, int'(lst_size) - 2) : 0;
        default: k = $urandom_range(0, int'(lst_size) - 1);
      endcase
      repeat (k) h = node_next[h];
    end
    op.word.anchor_handle = h;
    // bursts of back-to-back words separated by random gaps
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      op.gap = $urandom_range(1, 12);
    end else begin
      op.gap = 0;
    end
    burst_left--;
    sent_cnt++;
    op_q.insert(op_q.size(), op);
  endtask

  task automatic send_random(input int ins_pct);
    logic [1:0] md;
    anchor_pick_t pk;
    if ($urandom_range(0, 99) < ins_pct) begin
      md = 2'($urandom_range(0, 2));
      pk = $urandom_range(0, 1) ? AT_ANY : anchor_pick_t'($urandom_range(0, 2));
      send(md, $urandom, pk, 1'($urandom_range(0, 1)));
    end else begin
      send(dll_pkg::MODE_REMOVE, $urandom, AT_ANY, 1'($urandom_range(0, 1)));
    end
  endtask

  // Sample the handshake and predict each accepted word
  always @(posedge clk) begin
    took = !rst && start && !busy;
    if (took) apply_list_op(request);
  end

  // Drive request words at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        op_q.delete(0);
        loaded = 1'b0;
      end
      if (!loaded && op_q.size() != 0) begin
        idle_left = op_q[0].gap;
        loaded = 1'b1;
      end
      if (loaded && idle_left == 0) begin
        start <= 1'b1;
        request <= op_q[0].word;
      end else begin
        start <= 1'b0;
        if (loaded) idle_left--;
      end
    end
  end

  // Check each strobed result word against the oldest prediction
  always @(posedge clk) begin : check_results
    dll_pkg::out_word_t want;
    if (!rst && done) begin
      if (due_results.size() == 0) begin
        log_mismatch("result word with none due", 32'(response.element_count), 0);
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (response.status !== want.status)
          log_mismatch("status", 32'(response.status), 32'(want.status));
        if (response.new_handle !== want.new_handle)
          log_mismatch("new_handle", 32'(response.new_handle), 32'(want.new_handle));
        if (response.removed_value !== want.removed_value)
          log_mismatch("removed_value", response.removed_value, want.removed_value);
        if (response.element_count !== want.element_count)
          log_mismatch("element_count", 32'(response.element_count),
                       32'(want.element_count));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    // empty list, all handles free and handed out from zero
    for (int i = 0; i < NODES; i++) begin
      node_val[i] = '0;
      node_prev[i] = '0;
      node_next[i] = '0;
      free_stk[i] = 10'(NODES - 1 - i);
    end
    free_top = 11'(NODES);
    lst_head = '0;
    lst_tail = '0;
    lst_size = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // errors on the empty list
    send(dll_pkg::MODE_REMOVE, 32'h0, AT_ANY, 1'b0);
    send(dll_pkg::MODE_INSERT, 32'hffff_ffff, AT_ANY, 1'b1);
    // value extremes at both ends
    send(dll_pkg::MODE_APPEND, 32'h7fff_ffff, AT_ANY, 1'b0);
    send(dll_pkg::MODE_APPEND, 32'h8000_0000, AT_ANY, 1'b0);
    send(dll_pkg::MODE_PREPEND, 32'hffff_ffff, AT_ANY, 1'b1);
    send(dll_pkg::MODE_PREPEND, 32'h0, AT_ANY, 1'b0);
    // anchor at an end acts as prepend or append
    send(dll_pkg::MODE_INSERT, 32'h1, AT_HEAD, 1'b1);
    send(dll_pkg::MODE_INSERT, 32'h2, AT_TAIL, 1'b0);
    // splice into the middle
    send(dll_pkg::MODE_INSERT, 32'h3, AT_INNER, 1'b1);
    send(dll_pkg::MODE_INSERT, 32'h4, AT_INNER, 1'b0);
    send(dll_pkg::MODE_INSERT, 32'h5, AT_TAIL, 1'b1);
    send(dll_pkg::MODE_INSERT, 32'h6, AT_HEAD, 1'b0);
    // release handles, reuse one, then drain the list and restart it
    repeat (3) send(dll_pkg::MODE_REMOVE, 32'h0, AT_ANY, 1'b0);
    send(dll_pkg::MODE_APPEND, 32'h5a5a_a5a5, AT_ANY, 1'b0);
    repeat (8) send(dll_pkg::MODE_REMOVE, 32'h0, AT_ANY, 1'b0);
    send(dll_pkg::MODE_APPEND, 32'ha5a5_5a5a, AT_ANY, 1'b1);

    // short list that keeps running empty
    repeat (250) send_random(50);
    // grow until the pool is full
    while (lst_size < NODES) send_random(96);
    // churn around the full mark
    repeat (150) send_random(50);

    while (op_q.size() != 0 || due_results.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
